/* design/dtach_pkg.sv */
// ----------------------------------------------------------------------------
// Tachometer package
// Shared types and constants for the directional tachometer with digit split.
// ----------------------------------------------------------------------------
package dtach_pkg;

  localparam int SCALE_W  = 12;
  localparam int LIMIT_W  = 17;
  localparam int BAR_W    = 10;
  localparam int SPEED_W  = 28;
  localparam int PULSES_W = 16;
  localparam int DIGIT_W  = 4;
  localparam int SHOWN_W  = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [SPEED_W-1:0]  SPEED_MAX  = '1;
  localparam logic [PULSES_W-1:0] PULSES_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_PULSE_SCALE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAR_MAX       = 2'd2;

  // Reciprocal constants for exact division of a 17-bit value.
  localparam int DIV_W = 35;
  localparam logic [DIV_W-1:0] RECIP_10    = 35'd209716;
  localparam int               SHIFT_10    = 21;
  localparam logic [DIV_W-1:0] RECIP_100   = 35'd167773;
  localparam int               SHIFT_100   = 24;
  localparam logic [DIV_W-1:0] RECIP_1000  = 35'd134218;
  localparam int               SHIFT_1000  = 27;
  localparam logic [DIV_W-1:0] RECIP_10000 = 35'd107375;
  localparam int               SHIFT_10000 = 30;
  localparam logic [SHOWN_W-1:0] RADIX = 17'd10;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  typedef enum logic [1:0] {
    OP_SENSOR_ONE = 2'd0,
    OP_SENSOR_TWO = 2'd1,
    OP_TICK       = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    DIR_NONE    = 2'd0,
    DIR_FORWARD = 2'd1,
    DIR_REVERSE = 2'd2
  } dir_t;

  typedef struct packed {
    logic [SCALE_W-1:0] pulse_scale;
    logic [LIMIT_W-1:0] display_limit;
    logic [BAR_W-1:0]   bar_max;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    pulse_scale:   12'd720,
    display_limit: 17'd100000,
    bar_max:       10'd414
  };

  typedef struct packed {
    logic [SPEED_W-1:0]  speed;
    dir_t                dir;
    logic [PULSES_W-1:0] pulses;
  } entry_t;

endpackage

/* design/directional_tachometer_with_digits.sv */
// ----------------------------------------------------------------------------
// Directional tachometer with digits
// Throughput: one beat per cycle while the queue has room; in_ready is low when it is full.
// The display stage is a two-register pipeline behind a two-entry queue.
// Reset clears count, direction, speed and shown value and loads the default
// configuration; the block accepts beats in the first cycle after reset.
// ----------------------------------------------------------------------------
module directional_tachometer_with_digits #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           opcode,
  input  logic                                 other_sensor_level,
  input  logic                                 cfg_we,
  input  logic [dtach_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dtach_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [dtach_pkg::SPEED_W-1:0]        speed_hundredths,
  output logic [1:0]                           direction_code,
  output logic [dtach_pkg::PULSES_W-1:0]       pulses_so_far,
  output logic [dtach_pkg::DIGIT_W-1:0]        digit_hundreds,
  output logic [dtach_pkg::DIGIT_W-1:0]        digit_tens,
  output logic [dtach_pkg::DIGIT_W-1:0]        digit_ones,
  output logic [dtach_pkg::DIGIT_W-1:0]        digit_tenths,
  output logic [dtach_pkg::DIGIT_W-1:0]        digit_hundredths,
  output logic [dtach_pkg::BAR_W-1:0]          bar_length,
  output logic                                 shown_updated
);

  dtach_pkg::cfg_t   cfg;
  logic              q_full;
  logic              q_push;
  dtach_pkg::entry_t q_push_entry;
  logic              q_pop;
  logic              q_not_empty;
  dtach_pkg::entry_t q_pop_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= dtach_pkg::CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dtach_pkg::REG_PULSE_SCALE:   cfg.pulse_scale   <= cfg_data[dtach_pkg::SCALE_W-1:0];
        dtach_pkg::REG_DISPLAY_LIMIT: cfg.display_limit <= cfg_data[dtach_pkg::LIMIT_W-1:0];
        dtach_pkg::REG_BAR_MAX:       cfg.bar_max       <= cfg_data[dtach_pkg::BAR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dtach_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .opcode            (opcode),
    .other_sensor_level(other_sensor_level),
    .cfg               (cfg),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_entry           (q_push_entry)
  );

  dtach_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_entry(q_push_entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_entry (q_pop_entry)
  );

  dtach_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .q_not_empty     (q_not_empty),
    .q_entry         (q_pop_entry),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .speed_hundredths(speed_hundredths),
    .direction_code  (direction_code),
    .pulses_so_far   (pulses_so_far),
    .digit_hundreds  (digit_hundreds),
    .digit_tens      (digit_tens),
    .digit_ones      (digit_ones),
    .digit_tenths    (digit_tenths),
    .digit_hundredths(digit_hundredths),
    .bar_length      (bar_length),
    .shown_updated   (shown_updated)
  );

endmodule

/* design/dtach_front.sv */
// ----------------------------------------------------------------------------
// Tachometer front end
// Accepts sensor edges and gate ticks, keeps count, direction and gated speed.
// ----------------------------------------------------------------------------
module dtach_front #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            opcode,
  input  logic                  other_sensor_level,
  input  dtach_pkg::cfg_t       cfg,
  input  logic                  q_full,
  output logic                  q_push,
  output dtach_pkg::entry_t     q_entry
);

  localparam int PROD_W  = COUNT_WIDTH + dtach_pkg::SCALE_W;
  localparam int EXT_W   = (PROD_W > dtach_pkg::SPEED_W) ? PROD_W : dtach_pkg::SPEED_W;
  localparam int CLAMP_W = (COUNT_WIDTH > dtach_pkg::PULSES_W) ? COUNT_WIDTH
                                                                : dtach_pkg::PULSES_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [COUNT_WIDTH-1:0]           pulse_count, pulse_count_next;
  dtach_pkg::dir_t                  direction, direction_next;
  logic [dtach_pkg::SPEED_W-1:0]    gated_speed, gated_speed_next;
  logic                             edge_hit;
  logic                             tick;
  dtach_pkg::dir_t                  edge_dir;
  logic [PROD_W-1:0]                prod;
  logic [EXT_W-1:0]                 prod_ext;
  logic [dtach_pkg::SPEED_W-1:0]    speed_sat;
  logic [CLAMP_W-1:0]               count_ext;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  assign prod      = PROD_W'(pulse_count) * PROD_W'(cfg.pulse_scale);
  assign prod_ext  = EXT_W'(prod);
  assign speed_sat = (prod_ext > EXT_W'(dtach_pkg::SPEED_MAX)) ? dtach_pkg::SPEED_MAX
                                                                : prod_ext[dtach_pkg::SPEED_W-1:0];

  always_comb begin
    edge_hit = 1'b0;
    tick     = 1'b0;
    edge_dir = dtach_pkg::DIR_NONE;
    case (opcode)
      dtach_pkg::OP_SENSOR_ONE: begin
        edge_hit = !other_sensor_level;
        edge_dir = dtach_pkg::DIR_FORWARD;
      end
      dtach_pkg::OP_SENSOR_TWO: begin
        edge_hit = !other_sensor_level;
        edge_dir = dtach_pkg::DIR_REVERSE;
      end
      dtach_pkg::OP_TICK: begin
        tick = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    pulse_count_next = pulse_count;
    direction_next   = direction;
    gated_speed_next = gated_speed;
    if (edge_hit) begin
      if (direction == edge_dir) begin
        if (pulse_count != COUNT_MAX) begin
          pulse_count_next = pulse_count + COUNT_WIDTH'(1);
        end
      end else begin
        direction_next   = edge_dir;
        pulse_count_next = COUNT_WIDTH'(1);
      end
    end else if (tick) begin
      gated_speed_next = speed_sat;
      pulse_count_next = '0;
    end
  end

  assign count_ext      = CLAMP_W'(pulse_count_next);
  assign q_entry.speed  = gated_speed_next;
  assign q_entry.dir    = direction_next;
  assign q_entry.pulses = (count_ext > CLAMP_W'(dtach_pkg::PULSES_MAX))
                          ? dtach_pkg::PULSES_MAX : count_ext[dtach_pkg::PULSES_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_count <= '0;
      direction   <= dtach_pkg::DIR_NONE;
      gated_speed <= '0;
    end else if (q_push) begin
      pulse_count <= pulse_count_next;
      direction   <= direction_next;
      gated_speed <= gated_speed_next;
    end
  end

endmodule

/* design/dtach_queue.sv */
// ----------------------------------------------------------------------------
// Tachometer queue
// Small first-in first-out buffer between the front end and the display stage.
// ----------------------------------------------------------------------------
module dtach_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dtach_pkg::entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output dtach_pkg::entry_t pop_entry
);

  dtach_pkg::entry_t                store [dtach_pkg::QUEUE_DEPTH];
  logic [dtach_pkg::QPTR_W-1:0]     wr_ptr;
  logic [dtach_pkg::QPTR_W-1:0]     rd_ptr;
  logic [dtach_pkg::QPTR_W:0]       fill;

  assign full      = (fill == (dtach_pkg::QPTR_W + 1)'(dtach_pkg::QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign pop_entry = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + dtach_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + dtach_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + (dtach_pkg::QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (dtach_pkg::QPTR_W + 1)'(1);
      end
    end
  end

endmodule

/* design/dtach_back.sv */
// ----------------------------------------------------------------------------
// Tachometer display stage
// Latches the shown value and splits it into decimal digits and a bar length.
// ----------------------------------------------------------------------------
module dtach_back (
  input  logic                                clk,
  input  logic                                rst,
  input  dtach_pkg::cfg_t                     cfg,
  input  logic                                q_not_empty,
  input  dtach_pkg::entry_t                   q_entry,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dtach_pkg::SPEED_W-1:0]       speed_hundredths,
  output logic [1:0]                          direction_code,
  output logic [dtach_pkg::PULSES_W-1:0]      pulses_so_far,
  output logic [dtach_pkg::DIGIT_W-1:0]       digit_hundreds,
  output logic [dtach_pkg::DIGIT_W-1:0]       digit_tens,
  output logic [dtach_pkg::DIGIT_W-1:0]       digit_ones,
  output logic [dtach_pkg::DIGIT_W-1:0]       digit_tenths,
  output logic [dtach_pkg::DIGIT_W-1:0]       digit_hundredths,
  output logic [dtach_pkg::BAR_W-1:0]         bar_length,
  output logic                                shown_updated
);

  logic                            s1_valid;
  dtach_pkg::entry_t               s1_entry;
  logic                            s1_updated;
  logic [dtach_pkg::SHOWN_W-1:0]   shown_value;
  logic                            s1_load;
  logic                            s2_load;
  logic                            within_limit;
  logic [dtach_pkg::DIV_W-1:0]     shown_ext;
  logic [dtach_pkg::DIV_W-1:0]     prod_10, prod_100, prod_1000, prod_10000;
  logic [dtach_pkg::SHOWN_W-1:0]   q10, q100, q1000, q10000;
  logic [dtach_pkg::SHOWN_W-1:0]   rem_hundredths, rem_tenths, rem_ones, rem_tens;

  assign s2_load      = !out_valid || out_ready;
  assign s1_load      = !s1_valid || s2_load;
  assign q_pop        = q_not_empty && s1_load;
  assign within_limit = (q_entry.speed <= dtach_pkg::SPEED_W'(cfg.display_limit));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      shown_value <= '0;
    end else begin
      if (s1_load) begin
        s1_valid <= q_not_empty;
      end
      if (q_pop && within_limit) begin
        shown_value <= q_entry.speed[dtach_pkg::SHOWN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_entry   <= q_entry;
      s1_updated <= within_limit;
    end
  end

  assign shown_ext  = dtach_pkg::DIV_W'(shown_value);
  assign prod_10    = shown_ext * dtach_pkg::RECIP_10;
  assign prod_100   = shown_ext * dtach_pkg::RECIP_100;
  assign prod_1000  = shown_ext * dtach_pkg::RECIP_1000;
  assign prod_10000 = shown_ext * dtach_pkg::RECIP_10000;
  assign q10        = dtach_pkg::SHOWN_W'(prod_10 >> dtach_pkg::SHIFT_10);
  assign q100       = dtach_pkg::SHOWN_W'(prod_100 >> dtach_pkg::SHIFT_100);
  assign q1000      = dtach_pkg::SHOWN_W'(prod_1000 >> dtach_pkg::SHIFT_1000);
  assign q10000     = dtach_pkg::SHOWN_W'(prod_10000 >> dtach_pkg::SHIFT_10000);

  assign rem_hundredths = shown_value - q10 * dtach_pkg::RADIX;
  assign rem_tenths     = q10 - q100 * dtach_pkg::RADIX;
  assign rem_ones       = q100 - q1000 * dtach_pkg::RADIX;
  assign rem_tens       = q1000 - q10000 * dtach_pkg::RADIX;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid) begin
      speed_hundredths <= s1_entry.speed;
      direction_code   <= s1_entry.dir;
      pulses_so_far    <= s1_entry.pulses;
      shown_updated    <= s1_updated;
      digit_hundreds   <= q10000[dtach_pkg::DIGIT_W-1:0];
      digit_tens       <= rem_tens[dtach_pkg::DIGIT_W-1:0];
      digit_ones       <= rem_ones[dtach_pkg::DIGIT_W-1:0];
      digit_tenths     <= rem_tenths[dtach_pkg::DIGIT_W-1:0];
      digit_hundredths <= rem_hundredths[dtach_pkg::DIGIT_W-1:0];
      bar_length       <= (q100 >= dtach_pkg::SHOWN_W'(cfg.bar_max))
                          ? cfg.bar_max : q100[dtach_pkg::BAR_W-1:0];
    end
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Directional tachometer testbench
// Sends sensor edges, gate ticks and unused codes into the tachometer with
// random gaps and output stalls. Each accepted beat is run through an
// in-bench model of the counter, gate and digit split. The expected readings
// are checked field by field against the results, in order, under several
// register settings that include the extremes.
// ----------------------------------------------------------------------------
module tb;

  localparam int TACH_COUNT_W = 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic       lvl;
  } sensor_beat_t;

  typedef struct {
    logic [dtach_pkg::SPEED_W-1:0]  speed;
    dtach_pkg::dir_t                dir;
    logic [dtach_pkg::PULSES_W-1:0] pulses;
    logic [dtach_pkg::DIGIT_W-1:0]  d_hundreds;
    logic [dtach_pkg::DIGIT_W-1:0]  d_tens;
    logic [dtach_pkg::DIGIT_W-1:0]  d_ones;
    logic [dtach_pkg::DIGIT_W-1:0]  d_tenths;
    logic [dtach_pkg::DIGIT_W-1:0]  d_hundredths;
    logic [dtach_pkg::BAR_W-1:0]    bar;
    logic                           updated;
  } tach_reading_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [1:0]                       opcode = 2'd0;
  logic                             other_sensor_level = 1'b0;
  logic                             cfg_we = 1'b0;
  logic [dtach_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [dtach_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [dtach_pkg::SPEED_W-1:0]    speed_hundredths;
  logic [1:0]                       direction_code;
  logic [dtach_pkg::PULSES_W-1:0]   pulses_so_far;
  logic [dtach_pkg::DIGIT_W-1:0]    digit_hundreds;
  logic [dtach_pkg::DIGIT_W-1:0]    digit_tens;
  logic [dtach_pkg::DIGIT_W-1:0]    digit_ones;
  logic [dtach_pkg::DIGIT_W-1:0]    digit_tenths;
  logic [dtach_pkg::DIGIT_W-1:0]    digit_hundredths;
  logic [dtach_pkg::BAR_W-1:0]      bar_length;
  logic                             shown_updated;

  // Model state and register copies.
  logic [dtach_pkg::SCALE_W-1:0] scale_cfg  = dtach_pkg::CFG_RESET.pulse_scale;
  logic [dtach_pkg::LIMIT_W-1:0] limit_cfg  = dtach_pkg::CFG_RESET.display_limit;
  logic [dtach_pkg::BAR_W-1:0]   barmax_cfg = dtach_pkg::CFG_RESET.bar_max;
  logic [TACH_COUNT_W-1:0]       pulse_cnt  = '0;
  dtach_pkg::dir_t               dir_q      = dtach_pkg::DIR_NONE;
  logic [dtach_pkg::SPEED_W-1:0] speed_q    = '0;
  logic [dtach_pkg::SHOWN_W-1:0] shown_q    = '0;

  sensor_beat_t  beat_queue[$];
  tach_reading_t expected_readings[$];
  sensor_beat_t  cur_beat;
  int            mismatches = 0;
  int            cycle_count = 0;
  int            send_gap_max = 12;
  int            recv_stall_max = 12;
  int            gap_left = 0;
  int            stall_left = 0;
  logic          in_taken = 1'b0;
  logic          out_taken = 1'b0;
  logic          send_busy;

  directional_tachometer_with_digits #(
    .COUNT_WIDTH(TACH_COUNT_W)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .other_sensor_level(other_sensor_level),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .speed_hundredths(speed_hundredths),
    .direction_code(direction_code),
    .pulses_so_far(pulses_so_far),
    .digit_hundreds(digit_hundreds),
    .digit_tens(digit_tens),
    .digit_ones(digit_ones),
    .digit_tenths(digit_tenths),
    .digit_hundredths(digit_hundredths),
    .bar_length(bar_length),
    .shown_updated(shown_updated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void count_edge(input dtach_pkg::dir_t d);
    if (dir_q == d) begin
      if (pulse_cnt != '1) pulse_cnt = pulse_cnt + 1'b1;
    end else begin
      dir_q = d;
      pulse_cnt = TACH_COUNT_W'(1);
    end
  endfunction

  function automatic tach_reading_t tach_predict(input logic [1:0] op, input logic lvl);
    tach_reading_t r;
    logic [63:0]   prod;
    logic [16:0]   bar_full;
    case (op)
      dtach_pkg::OP_SENSOR_ONE: if (!lvl) count_edge(dtach_pkg::DIR_FORWARD);
      dtach_pkg::OP_SENSOR_TWO: if (!lvl) count_edge(dtach_pkg::DIR_REVERSE);
      dtach_pkg::OP_TICK: begin
        prod = 64'(pulse_cnt) * 64'(scale_cfg);
        speed_q = (prod > 64'(dtach_pkg::SPEED_MAX)) ? dtach_pkg::SPEED_MAX
                                                      : prod[dtach_pkg::SPEED_W-1:0];
        pulse_cnt = '0;
      end
      default: ;
    endcase
    r.updated = 1'b0;
    if (speed_q <= 28'(limit_cfg)) begin
      shown_q = speed_q[dtach_pkg::SHOWN_W-1:0];
      r.updated = 1'b1;
    end
    bar_full = shown_q / 17'd100;
    if (bar_full >= 17'(barmax_cfg)) bar_full = 17'(barmax_cfg);
    r.speed = speed_q;
    r.dir = dir_q;
    r.pulses = pulse_cnt;
    r.d_hundreds = 4'(shown_q / 17'd10000);
    r.d_tens = 4'((shown_q / 17'd1000) % 17'd10);
    r.d_ones = 4'((shown_q / 17'd100) % 17'd10);
    r.d_tenths = 4'((shown_q / 17'd10) % 17'd10);
    r.d_hundredths = 4'(shown_q % 17'd10);
    r.bar = bar_full[dtach_pkg::BAR_W-1:0];
    return r;
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    tach_reading_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** directional_tachometer_with_digits: FAILED **");
      $finish;
    end
    in_taken <= in_valid && in_ready;
    out_taken <= out_valid && out_ready;
    if (out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got speed %0d", $time,
                 speed_hundredths);
        mismatches++;
      end else begin
        want = expected_readings.pop_front();
        check_field("speed_hundredths", 32'(want.speed), 32'(speed_hundredths));
        check_field("direction_code", 32'(want.dir), 32'(direction_code));
        check_field("pulses_so_far", 32'(want.pulses), 32'(pulses_so_far));
        check_field("digit_hundreds", 32'(want.d_hundreds), 32'(digit_hundreds));
        check_field("digit_tens", 32'(want.d_tens), 32'(digit_tens));
        check_field("digit_ones", 32'(want.d_ones), 32'(digit_ones));
        check_field("digit_tenths", 32'(want.d_tenths), 32'(digit_tenths));
        check_field("digit_hundredths", 32'(want.d_hundredths), 32'(digit_hundredths));
        check_field("bar_length", 32'(want.bar), 32'(bar_length));
        check_field("shown_updated", 32'(want.updated), 32'(shown_updated));
      end
    end
    if (in_valid && in_ready)
      expected_readings.push_back(tach_predict(opcode, other_sensor_level));
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      send_busy = in_valid && !in_taken;
      if (in_taken) gap_left = $urandom_range(0, send_gap_max);
      if (!send_busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (beat_queue.size() > 0) begin
          cur_beat = beat_queue.pop_front();
          opcode <= cur_beat.op;
          other_sensor_level <= cur_beat.lvl;
          send_busy = 1'b1;
        end
      end
      in_valid <= send_busy;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_taken) stall_left = $urandom_range(0, recv_stall_max);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic queue_beat(input logic [1:0] op, input logic lvl);
    sensor_beat_t b;
    b.op = op;
    b.lvl = lvl;
    beat_queue.push_back(b);
  endtask

  task automatic queue_edges(input logic [1:0] op, input int n);
    for (int k = 0; k < n; k++) queue_beat(op, 1'b0);
  endtask

  task automatic wait_idle();
    while (beat_queue.size() != 0 || in_valid || expected_readings.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [dtach_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dtach_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      dtach_pkg::REG_PULSE_SCALE:   scale_cfg = value[dtach_pkg::SCALE_W-1:0];
      dtach_pkg::REG_DISPLAY_LIMIT: limit_cfg = value[dtach_pkg::LIMIT_W-1:0];
      dtach_pkg::REG_BAR_MAX:       barmax_cfg = value[dtach_pkg::BAR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_all_cfg(input int scale, input int limit, input int bar);
    write_cfg(dtach_pkg::REG_PULSE_SCALE, dtach_pkg::CFG_DATA_W'(scale));
    write_cfg(dtach_pkg::REG_DISPLAY_LIMIT, dtach_pkg::CFG_DATA_W'(limit));
    write_cfg(dtach_pkg::REG_BAR_MAX, dtach_pkg::CFG_DATA_W'(bar));
  endtask

  task automatic random_phase(input int n_beats);
    int                 done;
    int                 run_len;
    dtach_pkg::opcode_t lead;
    logic [1:0]         op;
    logic               lvl;
    done = 0;
    while (done < n_beats) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) == 1) queue_beat(OP_UNUSED, 1'($urandom_range(0, 1)));
        else queue_beat($urandom_range(0, 1) ? dtach_pkg::OP_SENSOR_ONE
                                             : dtach_pkg::OP_SENSOR_TWO, 1'b1);
      end else begin
        lead = ($urandom_range(0, 1) == 1) ? dtach_pkg::OP_SENSOR_ONE
                                           : dtach_pkg::OP_SENSOR_TWO;
        run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 120) : $urandom_range(0, 12);
        for (int k = 0; k < run_len; k++) begin
          op = lead;
          if ($urandom_range(0, 7) == 0)
            op = (lead == dtach_pkg::OP_SENSOR_ONE) ? dtach_pkg::OP_SENSOR_TWO
                                                    : dtach_pkg::OP_SENSOR_ONE;
          lvl = ($urandom_range(0, 9) == 0);
          queue_beat(op, lvl);
          if (!lvl) done++;
        end
        queue_beat(dtach_pkg::OP_TICK, 1'($urandom_range(0, 1)));
        done++;
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Default registers: direction changes, ignored edges and unused codes.
    queue_beat(dtach_pkg::OP_TICK, 1'b1);
    queue_beat(OP_UNUSED, 1'b0);
    queue_beat(OP_UNUSED, 1'b1);
    queue_beat(dtach_pkg::OP_SENSOR_ONE, 1'b1);
    queue_edges(dtach_pkg::OP_SENSOR_ONE, 3);
    queue_beat(dtach_pkg::OP_SENSOR_TWO, 1'b1);
    queue_edges(dtach_pkg::OP_SENSOR_TWO, 2);
    queue_edges(dtach_pkg::OP_SENSOR_ONE, 1);
    queue_beat(dtach_pkg::OP_TICK, 1'b0);
    queue_edges(dtach_pkg::OP_SENSOR_TWO, 5);
    queue_beat(dtach_pkg::OP_TICK, 1'b0);
    queue_edges(dtach_pkg::OP_SENSOR_ONE, 2);
    queue_beat(dtach_pkg::OP_TICK, 1'b1);
    wait_idle();

    // Largest registers: hundreds digit above nine, bar clamp, speed over the limit.
    set_all_cfg(4095, 131071, 1023);
    queue_edges(dtach_pkg::OP_SENSOR_ONE, 30);
    queue_beat(dtach_pkg::OP_TICK, 1'b0);
    queue_edges(dtach_pkg::OP_SENSOR_TWO, 33);
    queue_beat(dtach_pkg::OP_TICK, 1'b0);
    queue_beat(dtach_pkg::OP_TICK, 1'b0);
    wait_idle();

    // Speed exactly at the limit, then just above it.
    set_all_cfg(1000, 5000, 50);
    queue_edges(dtach_pkg::OP_SENSOR_ONE, 5);
    queue_beat(dtach_pkg::OP_TICK, 1'b0);
    queue_edges(dtach_pkg::OP_SENSOR_ONE, 6);
    queue_beat(dtach_pkg::OP_TICK, 1'b0);
    wait_idle();

    // All registers at zero.
    set_all_cfg(0, 0, 0);
    queue_edges(dtach_pkg::OP_SENSOR_TWO, 3);
    queue_beat(dtach_pkg::OP_TICK, 1'b0);
    wait_idle();
    write_cfg(dtach_pkg::REG_PULSE_SCALE, dtach_pkg::CFG_DATA_W'(1));
    queue_edges(dtach_pkg::OP_SENSOR_TWO, 1);
    queue_beat(dtach_pkg::OP_TICK, 1'b0);
    wait_idle();

    // A long back-to-back run at the largest scale.
    set_all_cfg(4095, 100000, 414);
    send_gap_max = 0;
    recv_stall_max = 0;
    queue_edges(dtach_pkg::OP_SENSOR_ONE, 60);
    queue_beat(dtach_pkg::OP_TICK, 1'b0);
    queue_beat(dtach_pkg::OP_TICK, 1'b0);
    wait_idle();

    for (int ph = 0; ph < 5; ph++) begin
      send_gap_max = (ph == 1 || ph == 3) ? 0 : 12;
      recv_stall_max = (ph == 1 || ph == 2) ? 0 : 12;
      set_all_cfg(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(1, 400),
                  ($urandom_range(0, 1) == 1) ? 100000 : $urandom_range(0, 131071),
                  $urandom_range(0, 1023));
      random_phase(40);
    end

    if (mismatches == 0) begin
      $display("** directional_tachometer_with_digits: PASSED **");
    end else begin
      $display("** directional_tachometer_with_digits: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/dtach_pkg.sv
design/dtach_front.sv
design/dtach_queue.sv
design/dtach_back.sv
design/directional_tachometer_with_digits.sv
verif/tb.sv
